// ===== src/icmp_chk_pkg.sv =====
// Shared types, status codes and constants for the ICMP echo reply checker.
package icmp_chk_pkg;

    // Status codes reported with each packet result.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_SUM   = 3'd1;
    localparam logic [2:0] ST_NOT_REPLY = 3'd2;
    localparam logic [2:0] ST_BAD_ID    = 3'd3;
    localparam logic [2:0] ST_MALFORMED = 3'd4;

    // Byte positions in the IPv4 header.
    localparam logic [15:0] POS_VER_IHL  = 16'd0;
    localparam logic [15:0] POS_LEN_HI   = 16'd2;
    localparam logic [15:0] POS_LEN_LO   = 16'd3;
    localparam logic [15:0] POS_TTL      = 16'd8;
    localparam logic [15:0] MIN_HDR      = 16'd20;
    localparam logic [15:0] COUNT_MAX    = 16'hffff;

    // Byte offsets in the ICMP message.
    localparam logic [15:0] OFF_TYPE     = 16'd0;
    localparam logic [15:0] OFF_ID_HI    = 16'd4;
    localparam logic [15:0] OFF_ID_LO    = 16'd5;
    localparam logic [15:0] OFF_SEQ_HI   = 16'd6;
    localparam logic [15:0] OFF_SEQ_LO   = 16'd7;

    localparam logic [15:0] SUM_GOOD     = 16'hffff;

    // Per-packet fields handed from the parser to the status evaluation.
    typedef struct packed {
        logic [5:0]  header_bytes;
        logic [15:0] total_bytes;
        logic [15:0] byte_count;
        logic [15:0] ones_sum;
        logic [7:0]  pending_high;
        logic [7:0]  msg_type;
        logic [15:0] msg_ident;
        logic [15:0] msg_seq;
        logic [7:0]  ttl_seen;
    } pkt_summary_t;

    // Ones-complement add of two 16-bit words with end-around carry.
    function automatic logic [15:0] fold_add(input logic [15:0] s, input logic [15:0] w);
        logic [16:0] t;
        t = {1'b0, s} + {1'b0, w};
        return t[15:0] + {15'd0, t[16]};
    endfunction

endpackage

// ===== src/icmp_chk_parser.sv =====
// Byte parser: tracks header fields, ICMP fields and the running checksum.
module icmp_chk_parser (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [7:0]                 pkt_byte,
    input  logic                       last_byte,
    output icmp_chk_pkg::pkt_summary_t summary
);
    import icmp_chk_pkg::*;

    logic [15:0] byte_index_reg, byte_index_next;
    logic [5:0]  header_bytes_reg, header_bytes_next;
    logic [15:0] total_bytes_reg, total_bytes_next;
    logic [15:0] ones_sum_reg, ones_sum_next;
    logic [7:0]  pending_high_reg, pending_high_next;
    logic [7:0]  msg_type_reg, msg_type_next;
    logic [15:0] msg_ident_reg, msg_ident_next;
    logic [15:0] msg_seq_reg, msg_seq_next;
    logic [7:0]  ttl_seen_reg, ttl_seen_next;

    logic [15:0] offset;
    logic        in_icmp;

    // Offset into the ICMP message and whether this byte belongs to it.
    assign offset  = byte_index_reg - {10'd0, header_bytes_reg};
    assign in_icmp = (byte_index_reg >= MIN_HDR)
                  && ({10'd0, header_bytes_reg} >= MIN_HDR)
                  && (byte_index_reg >= {10'd0, header_bytes_reg})
                  && (byte_index_reg < total_bytes_reg);

    // Next per-packet state for the byte in this transaction.
    always_comb
    begin
        header_bytes_next = header_bytes_reg;
        total_bytes_next  = total_bytes_reg;
        ttl_seen_next     = ttl_seen_reg;
        msg_type_next     = msg_type_reg;
        msg_ident_next    = msg_ident_reg;
        msg_seq_next      = msg_seq_reg;
        pending_high_next = pending_high_reg;
        ones_sum_next     = ones_sum_reg;

        case (byte_index_reg)
            POS_VER_IHL: header_bytes_next = {pkt_byte[3:0], 2'b00};
            POS_LEN_HI:  total_bytes_next  = {pkt_byte, total_bytes_reg[7:0]};
            POS_LEN_LO:  total_bytes_next  = {total_bytes_reg[15:8], pkt_byte};
            POS_TTL:     ttl_seen_next     = pkt_byte;
            default:     ;
        endcase

        if (in_icmp)
        begin
            case (offset)
                OFF_TYPE:   msg_type_next  = pkt_byte;
                OFF_ID_HI:  msg_ident_next = {pkt_byte, msg_ident_reg[7:0]};
                OFF_ID_LO:  msg_ident_next = {msg_ident_reg[15:8], pkt_byte};
                OFF_SEQ_HI: msg_seq_next   = {pkt_byte, msg_seq_reg[7:0]};
                OFF_SEQ_LO: msg_seq_next   = {msg_seq_reg[15:8], pkt_byte};
                default:    ;
            endcase
            if (!offset[0])
            begin
                pending_high_next = pkt_byte;
            end
            else
            begin
                ones_sum_next = fold_add(ones_sum_reg, {pending_high_reg, pkt_byte});
            end
        end

        // The byte counter saturates on very long packets.
        if (byte_index_reg != COUNT_MAX)
        begin
            byte_index_next = byte_index_reg + 16'd1;
        end
        else
        begin
            byte_index_next = byte_index_reg;
        end
    end

    // Summary seen by the evaluation includes the current byte.
    always_comb
    begin
        summary.header_bytes = header_bytes_next;
        summary.total_bytes  = total_bytes_next;
        summary.byte_count   = byte_index_next;
        summary.ones_sum     = ones_sum_next;
        summary.pending_high = pending_high_next;
        summary.msg_type     = msg_type_next;
        summary.msg_ident    = msg_ident_next;
        summary.msg_seq      = msg_seq_next;
        summary.ttl_seen     = ttl_seen_next;
    end

    // State registers; the final byte clears everything for the next packet.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg   <= '0;
            header_bytes_reg <= '0;
            total_bytes_reg  <= '0;
            ones_sum_reg     <= '0;
            pending_high_reg <= '0;
            msg_type_reg     <= '0;
            msg_ident_reg    <= '0;
            msg_seq_reg      <= '0;
            ttl_seen_reg     <= '0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                byte_index_reg   <= '0;
                header_bytes_reg <= '0;
                total_bytes_reg  <= '0;
                ones_sum_reg     <= '0;
                pending_high_reg <= '0;
                msg_type_reg     <= '0;
                msg_ident_reg    <= '0;
                msg_seq_reg      <= '0;
                ttl_seen_reg     <= '0;
            end
            else
            begin
                byte_index_reg   <= byte_index_next;
                header_bytes_reg <= header_bytes_next;
                total_bytes_reg  <= total_bytes_next;
                ones_sum_reg     <= ones_sum_next;
                pending_high_reg <= pending_high_next;
                msg_type_reg     <= msg_type_next;
                msg_ident_reg    <= msg_ident_next;
                msg_seq_reg      <= msg_seq_next;
                ttl_seen_reg     <= ttl_seen_next;
            end
        end
    end

endmodule

// ===== src/icmp_chk_eval.sv =====
// Status evaluation: malformed, checksum, type and identifier checks.
module icmp_chk_eval (
    input  icmp_chk_pkg::pkt_summary_t summary,
    input  logic [15:0]                expected_id,
    output logic [2:0]                 status,
    output logic [15:0]                icmp_length
);
    import icmp_chk_pkg::*;

    logic [15:0] hdr_wide;
    logic        total_short;
    logic        malformed;
    logic [15:0] final_sum;

    assign hdr_wide    = {10'd0, summary.header_bytes};
    assign total_short = summary.total_bytes < hdr_wide;
    assign malformed   = (hdr_wide < MIN_HDR) || (summary.byte_count < MIN_HDR)
                      || (summary.byte_count < summary.total_bytes) || total_short;

    // ICMP length is zero when the total length is below the header length.
    assign icmp_length = total_short ? 16'd0 : (summary.total_bytes - hdr_wide);

    // An odd final byte is padded with a zero low byte.
    assign final_sum = icmp_length[0]
                     ? fold_add(summary.ones_sum, {summary.pending_high, 8'd0})
                     : summary.ones_sum;

    // Checks in priority order.
    always_comb
    begin
        if (malformed)
        begin
            status = ST_MALFORMED;
        end
        else if (final_sum != SUM_GOOD)
        begin
            status = ST_BAD_SUM;
        end
        else if (summary.msg_type != 8'd0)
        begin
            status = ST_NOT_REPLY;
        end
        else if (summary.msg_ident != expected_id)
        begin
            status = ST_BAD_ID;
        end
        else
        begin
            status = ST_OK;
        end
    end

endmodule

// ===== src/icmp_echo_reply_checker.sv =====
// ICMP echo reply checker: the result is registered and shown in the cycle after the final byte is accepted.
// Throughput: one byte per cycle; a byte is taken whenever the result register is
// empty or its result is being taken in the same cycle.
// Reset (rst_n, asynchronous, active low) clears the per-packet state, the result
// register and expected_id to zero.
// Per-packet state also clears itself after each final byte.
module icmp_echo_reply_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  pkt_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [15:0] icmp_length,
    output logic [15:0] echo_sequence,
    output logic [7:0]  time_to_live
);
    import icmp_chk_pkg::*;

    pkt_summary_t summary;
    logic         accept;
    logic [15:0]  expected_id_reg;
    logic [2:0]   eval_status;
    logic [15:0]  eval_length;
    logic         out_valid_reg, out_valid_next;
    logic [2:0]   status_reg;
    logic [15:0]  icmp_length_reg;
    logic [15:0]  echo_sequence_reg;
    logic [7:0]   time_to_live_reg;

    // Input transaction handshake.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    icmp_chk_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .pkt_byte  (pkt_byte),
        .last_byte (last_byte),
        .summary   (summary)
    );

    icmp_chk_eval u_eval (
        .summary     (summary),
        .expected_id (expected_id_reg),
        .status      (eval_status),
        .icmp_length (eval_length)
    );

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_id_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            expected_id_reg <= cfg_wr_data;
        end
    end

    // Result valid flag.
    always_comb
    begin
        if (accept && last_byte)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload register, loaded on the final byte of a packet.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg        <= '0;
            icmp_length_reg   <= '0;
            echo_sequence_reg <= '0;
            time_to_live_reg  <= '0;
        end
        else if (accept && last_byte)
        begin
            status_reg        <= eval_status;
            icmp_length_reg   <= eval_length;
            echo_sequence_reg <= summary.msg_seq;
            time_to_live_reg  <= summary.ttl_seen;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign icmp_length   = icmp_length_reg;
    assign echo_sequence = echo_sequence_reg;
    assign time_to_live  = time_to_live_reg;

endmodule
